[sv/spq_pkg.sv]
// Shared types and codes for the stable priority queue.
`default_nettype none

package spq_pkg;

    localparam int ID_W    = 16;
    localparam int PRI_W   = 8;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 3'd0,
        OP_DEQ  = 3'd1,
        OP_REM  = 3'd2,
        OP_FIND = 3'd3,
        OP_PEEK = 3'd4
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic enq;
        logic deq;
        logic rem;
    } cell_cmd_t;

endpackage

`default_nettype wire

[sv/stable_priority_queue_top.sv]
// Top level of the stable priority queue: request control, result register and the cell row.
//
//   Channel  | Handshake              | Fields
//   ---------+------------------------+---------------------------------------------------
//   request  | in_valid / in_ready    | opcode, ticket_id, ticket_priority
//   result   | out_valid / out_ready  | status, out_id, out_priority, pending_count
//
// In the accept cycle every cell compares the request against its entry and registers the flags;
// in the execute state the row moves and the result register is loaded.
// A new request is accepted only once the previous one has left the execute state; the execute state waits while an
// earlier result is still held and not taken.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module stable_priority_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [spq_pkg::OP_W-1:0]     opcode,
    input  wire logic [spq_pkg::ID_W-1:0]     ticket_id,
    input  wire logic [spq_pkg::PRI_W-1:0]    ticket_priority,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [spq_pkg::STAT_W-1:0]        status,
    output logic [spq_pkg::ID_W-1:0]          out_id,
    output logic [spq_pkg::PRI_W-1:0]         out_priority,
    output logic [spq_pkg::COUNT_W-1:0]       pending_count
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t           state_reg;
    state_t           state_next;
    opcode_t          op_reg;
    logic [ID_W-1:0]  req_id_reg;
    logic [PRI_W-1:0] req_pri_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic              out_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [ID_W-1:0]   out_id_next;
    logic [PRI_W-1:0]  out_pri_reg;
    logic [PRI_W-1:0]  out_pri_next;

    logic      accept;
    logic      exec_go;
    cell_cmd_t cmd;
    cell_cmd_t cmd_next;

    logic [ID_W-1:0]  cell_id   [QUEUE_DEPTH];
    logic [PRI_W-1:0] cell_pri  [QUEUE_DEPTH];
    logic             cell_ge   [QUEUE_DEPTH];
    logic             cell_seen [QUEUE_DEPTH];
    logic [ID_W-1:0]  hit_id    [QUEUE_DEPTH];
    logic [PRI_W-1:0] hit_pri   [QUEUE_DEPTH];

    logic empty;
    logic full;
    logic found;

    assign accept  = in_valid && in_ready;
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign found   = cell_seen[QUEUE_DEPTH-1];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_ready = 1'b0;
        exec_go  = 1'b0;
        unique case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_EXEC:  exec_go  = !out_valid_reg || out_ready;
            default:
            begin
                in_ready = 1'b0;
                exec_go  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode_t'(opcode);
            req_id_reg  <= ticket_id;
            req_pri_reg <= ticket_priority;
        end
    end

    // Result and row command for the request being executed.
    always_comb
    begin
        status_next  = ST_OK;
        out_id_next  = '0;
        out_pri_next = '0;
        count_next   = count_reg;
        cmd_next     = '0;
        unique case (op_reg)
            OP_ENQ:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    cmd_next.enq = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            OP_DEQ, OP_PEEK:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    out_id_next  = cell_id[0];
                    out_pri_next = cell_pri[0];
                    if (op_reg == OP_DEQ)
                    begin
                        cmd_next.deq = 1'b1;
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
            end
            OP_REM, OP_FIND:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else if (!found)
                    status_next = ST_NOTFOUND;
                else
                begin
                    out_id_next  = hit_id[QUEUE_DEPTH-1];
                    out_pri_next = hit_pri[QUEUE_DEPTH-1];
                    if (op_reg == OP_REM)
                    begin
                        cmd_next.rem = 1'b1;
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign cmd = exec_go ? cmd_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec_go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            status_reg  <= status_next;
            out_id_reg  <= out_id_next;
            out_pri_reg <= out_pri_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_id        = out_id_reg;
    assign out_priority  = out_pri_reg;
    assign pending_count = COUNT_W'(count_reg);

    // Row of cells; slot 0 is the head.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [ID_W-1:0]  l_id;
        logic [PRI_W-1:0] l_pri;
        logic             l_ge;
        logic [ID_W-1:0]  r_id;
        logic [PRI_W-1:0] r_pri;
        logic             s_in;
        logic [ID_W-1:0]  h_id;
        logic [PRI_W-1:0] h_pri;
        logic             slot_valid;

        assign slot_valid = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign l_id  = '0;
            assign l_pri = '0;
            assign l_ge  = 1'b1;
            assign s_in  = 1'b0;
            assign h_id  = '0;
            assign h_pri = '0;
        end
        else
        begin : g_body
            assign l_id  = cell_id[i-1];
            assign l_pri = cell_pri[i-1];
            assign l_ge  = cell_ge[i-1];
            assign s_in  = cell_seen[i-1];
            assign h_id  = hit_id[i-1];
            assign h_pri = hit_pri[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign r_id  = '0;
            assign r_pri = '0;
        end
        else
        begin : g_inner
            assign r_id  = cell_id[i+1];
            assign r_pri = cell_pri[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .capture     (accept),
            .slot_valid  (slot_valid),
            .req_id      (accept ? ticket_id : req_id_reg),
            .req_pri     (accept ? ticket_priority : req_pri_reg),
            .cmd         (cmd),
            .left_id     (l_id),
            .left_pri    (l_pri),
            .left_ge     (l_ge),
            .right_id    (r_id),
            .right_pri   (r_pri),
            .seen_in     (s_in),
            .hit_id_in   (h_id),
            .hit_pri_in  (h_pri),
            .id          (cell_id[i]),
            .pri         (cell_pri[i]),
            .ge          (cell_ge[i]),
            .seen_out    (cell_seen[i]),
            .hit_id_out  (hit_id[i]),
            .hit_pri_out (hit_pri[i])
        );
    end

endmodule

`default_nettype wire

[sv/spq_cell.sv]
// One slot of the sorted row: holds an entry and moves it toward either neighbor.
`default_nettype none

module spq_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     capture,
    input  wire logic                     slot_valid,
    input  wire logic [spq_pkg::ID_W-1:0]  req_id,
    input  wire logic [spq_pkg::PRI_W-1:0] req_pri,
    input  wire spq_pkg::cell_cmd_t        cmd,
    input  wire logic [spq_pkg::ID_W-1:0]  left_id,
    input  wire logic [spq_pkg::PRI_W-1:0] left_pri,
    input  wire logic                     left_ge,
    input  wire logic [spq_pkg::ID_W-1:0]  right_id,
    input  wire logic [spq_pkg::PRI_W-1:0] right_pri,
    input  wire logic                     seen_in,
    input  wire logic [spq_pkg::ID_W-1:0]  hit_id_in,
    input  wire logic [spq_pkg::PRI_W-1:0] hit_pri_in,
    output logic [spq_pkg::ID_W-1:0]       id,
    output logic [spq_pkg::PRI_W-1:0]      pri,
    output logic                          ge,
    output logic                          seen_out,
    output logic [spq_pkg::ID_W-1:0]       hit_id_out,
    output logic [spq_pkg::PRI_W-1:0]      hit_pri_out
);
    import spq_pkg::*;

    logic [ID_W-1:0]  id_reg;
    logic [ID_W-1:0]  id_next;
    logic [PRI_W-1:0] pri_reg;
    logic [PRI_W-1:0] pri_next;
    logic             ge_reg;
    logic             match_reg;
    logic             shift_left;

    // Compare flags are taken when the request is accepted and held until the request is executed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg    <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (capture)
        begin
            ge_reg    <= slot_valid && (pri_reg >= req_pri);
            match_reg <= slot_valid && (id_reg == req_id);
        end
    end

    // A removal closes the gap from the first matching slot onward.
    assign shift_left = cmd.deq || (cmd.rem && (seen_in || match_reg));

    always_comb
    begin
        id_next  = id_reg;
        pri_next = pri_reg;
        if (cmd.enq && !ge_reg)
        begin
            if (left_ge)
            begin
                id_next  = req_id;
                pri_next = req_pri;
            end
            else
            begin
                id_next  = left_id;
                pri_next = left_pri;
            end
        end
        else if (shift_left)
        begin
            id_next  = right_id;
            pri_next = right_pri;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        pri_reg <= pri_next;
    end

    assign id          = id_reg;
    assign pri         = pri_reg;
    assign ge          = ge_reg;
    assign seen_out    = seen_in || match_reg;
    assign hit_id_out  = (!seen_in && match_reg) ? id_reg  : hit_id_in;
    assign hit_pri_out = (!seen_in && match_reg) ? pri_reg : hit_pri_in;

endmodule

`default_nettype wire

[sim/spq_result_checker.sv]
// Result checker for the stable priority queue: tracks the queue contents and compares results.
`timescale 1ns / 100ps

module spq_result_checker
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [OP_W-1:0]     opcode,
    input  logic [ID_W-1:0]     ticket_id,
    input  logic [PRI_W-1:0]    ticket_priority,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [STAT_W-1:0]   status,
    input  logic [ID_W-1:0]     out_id,
    input  logic [PRI_W-1:0]    out_priority,
    input  logic [COUNT_W-1:0]  pending_count,
    output int                  error_count,
    output int                  awaited_count,
    output int                  results_checked,
    output int                  full_seen,
    output int                  empty_seen,
    output int                  miss_seen
);

    typedef struct {
        status_t              status;
        logic [ID_W-1:0]      id;
        logic [PRI_W-1:0]     pri;
        logic [COUNT_W-1:0]   count;
    } queue_result_t;

    // Our own copy of the sorted store, head at index 0.
    logic [ID_W-1:0]  held_ids  [QUEUE_DEPTH];
    logic [PRI_W-1:0] held_pris [QUEUE_DEPTH];
    int               held_total = 0;

    queue_result_t awaited_results[$];

    initial
    begin
        error_count     = 0;
        awaited_count   = 0;
        results_checked = 0;
        full_seen       = 0;
        empty_seen      = 0;
        miss_seen       = 0;
    end

    function automatic void close_gap(int pos);
        for (int i = pos; i + 1 < held_total; i++)
        begin
            held_ids[i]  = held_ids[i + 1];
            held_pris[i] = held_pris[i + 1];
        end
        held_total--;
    endfunction

    function automatic queue_result_t apply_request(logic [OP_W-1:0] op,
                                                    logic [ID_W-1:0] id,
                                                    logic [PRI_W-1:0] pri);
        queue_result_t r;
        int pos;
        r.status = ST_OK;
        r.id     = '0;
        r.pri    = '0;
        case (op)
            OP_ENQ:
            begin
                if (held_total >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // A new entry goes behind every entry of equal or higher priority.
                    pos = 0;
                    while (pos < held_total && held_pris[pos] >= pri)
                        pos++;
                    for (int i = held_total; i > pos; i--)
                    begin
                        held_ids[i]  = held_ids[i - 1];
                        held_pris[i] = held_pris[i - 1];
                    end
                    held_ids[pos]  = id;
                    held_pris[pos] = pri;
                    held_total++;
                end
            end
            OP_DEQ, OP_PEEK:
            begin
                if (held_total == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.id  = held_ids[0];
                    r.pri = held_pris[0];
                    if (op == OP_DEQ)
                        close_gap(0);
                end
            end
            OP_REM, OP_FIND:
            begin
                if (held_total == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    pos = 0;
                    while (pos < held_total && held_ids[pos] != id)
                        pos++;
                    if (pos == held_total)
                        r.status = ST_NOTFOUND;
                    else
                    begin
                        r.id  = held_ids[pos];
                        r.pri = held_pris[pos];
                        if (op == OP_REM)
                            close_gap(pos);
                    end
                end
            end
            default:
                ;
        endcase
        r.count = held_total[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n)
        begin
            // Results are checked before the new request is predicted; a result can never
            // belong to a request accepted in the same cycle.
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("Result arrived with no request awaiting it (status %0d, id %0h)",
                           status, out_id);
                    error_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    results_checked++;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        error_count++;
                    end
                    if (out_id !== want.id)
                    begin
                        $error("out_id: expected %0h, got %0h", want.id, out_id);
                        error_count++;
                    end
                    if (out_priority !== want.pri)
                    begin
                        $error("out_priority: expected %0d, got %0d", want.pri, out_priority);
                        error_count++;
                    end
                    if (pending_count !== want.count)
                    begin
                        $error("pending_count: expected %0d, got %0d", want.count,
                               pending_count);
                        error_count++;
                    end
                    case (want.status)
                        ST_FULL:     full_seen++;
                        ST_EMPTY:    empty_seen++;
                        ST_NOTFOUND: miss_seen++;
                        default:     ;
                    endcase
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(apply_request(opcode, ticket_id, ticket_priority));
            awaited_count = awaited_results.size();
        end
    end

endmodule

[sim/stable_priority_queue_top_tb.sv]
// Testbench top for the stable priority queue: request stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module stable_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 800;
    localparam int CYCLE_LIMIT   = 200000;
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     opcode;
    logic [ID_W-1:0]     ticket_id;
    logic [PRI_W-1:0]    ticket_priority;
    logic                out_valid;
    logic                out_ready;
    logic [STAT_W-1:0]   status;
    logic [ID_W-1:0]     out_id;
    logic [PRI_W-1:0]    out_priority;
    logic [COUNT_W-1:0]  pending_count;

    int error_count;
    int awaited_count;
    int results_checked;
    int full_seen;
    int empty_seen;
    int miss_seen;
    int requests_sent = 0;
    int cycle_count   = 0;
    bit steady        = 1'b0;

    stable_priority_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .ticket_id(ticket_id),
        .ticket_priority(ticket_priority),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .out_id(out_id),
        .out_priority(out_priority),
        .pending_count(pending_count)
    );

    spq_result_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .ticket_id(ticket_id),
        .ticket_priority(ticket_priority),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .out_id(out_id),
        .out_priority(out_priority),
        .pending_count(pending_count),
        .error_count(error_count),
        .awaited_count(awaited_count),
        .results_checked(results_checked),
        .full_seen(full_seen),
        .empty_seen(empty_seen),
        .miss_seen(miss_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $error("Run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 7);
    endfunction

    // Called right after a rising edge; the request is held until it is accepted.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                input logic [PRI_W-1:0] pri);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        opcode          <= op;
        ticket_id       <= id;
        ticket_priority <= pri;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    task automatic send_random(input bit filling);
        int roll;
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        else if (roll < (filling ? 68 : 28))
            op = OP_ENQ;
        else if (roll < (filling ? 76 : 58))
            op = OP_DEQ;
        else if (roll < (filling ? 84 : 78))
            op = OP_REM;
        else if (roll < 92)
            op = OP_FIND;
        else
            op = OP_PEEK;
        // A small id pool makes duplicates and hits common.
        if ($urandom_range(0, 4) == 0)
            id = ID_W'($urandom);
        else
            id = ID_W'(16'h5A00 + $urandom_range(0, 23));
        // A few priority levels give plenty of ties.
        if ($urandom_range(0, 2) == 0)
            pri = PRI_W'($urandom);
        else
            pri = PRI_W'($urandom_range(0, 3) * 85);
        send_request(op, id, pri);
    endtask

    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = draw_gap();
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        bit filling;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        opcode          = OP_ENQ;
        ticket_id       = '0;
        ticket_priority = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every lookup on an empty queue.
        send_request(OP_PEEK, 16'h0000, 8'h00);
        send_request(OP_DEQ, 16'h0000, 8'h00);
        send_request(OP_REM, 16'hFFFF, 8'hFF);
        send_request(OP_FIND, 16'hFFFF, 8'h00);

        // Extremes, a tie at the top priority and a duplicate id, then fill up and overflow.
        send_request(OP_ENQ, 16'hFFFF, 8'hFF);
        send_request(OP_ENQ, 16'h0000, 8'h00);
        send_request(OP_ENQ, 16'h1234, 8'hFF);
        send_request(OP_ENQ, 16'hFFFF, 8'h80);
        for (int i = 4; i < QUEUE_DEPTH; i++)
            send_request(OP_ENQ, ID_W'($urandom), PRI_W'($urandom));
        send_request(OP_ENQ, 16'hBEEF, 8'hFF);

        send_request(OP_PEEK, 16'h0000, 8'h00);
        send_request(OP_FIND, 16'hFFFF, 8'h00);
        send_request(OP_FIND, 16'hABCD, 8'h00);
        send_request(OP_REM, 16'h0000, 8'h00);
        send_request(OP_RSVD_FIRST, 16'hFFFF, 8'hFF);
        send_request(OP_RSVD_LAST, 16'h0000, 8'h00);
        send_request(OP_DEQ, 16'h0000, 8'h00);

        // Alternate fill and drain phases so the queue swings between empty and full.
        filling = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
                filling = ~filling;
            if (n % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_random(filling);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (awaited_count == 0);
        repeat (8) @(posedge clk);

        $display("Sent %0d requests and checked %0d results.", requests_sent, results_checked);
        $display("Results included %0d full, %0d empty and %0d id-not-found statuses.",
                 full_seen, empty_seen, miss_seen);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue_top.sv
sim/spq_result_checker.sv
sim/stable_priority_queue_top_tb.sv
